// File: rtl/sfmv_pkg.sv
// Shared types, codes and default sizes for the decision-stump forest voter.
// No dependencies; used by the core and its port checker.
package sfmv_pkg;

    // Default sizing, handed to the top level as parameter defaults.
    localparam int TREES_DEF    = 10;
    localparam int CLASSES_DEF  = 10;
    localparam int FEATURES_DEF = 16;

    // Fixed field widths.
    localparam int CLASS_W  = 4;
    localparam int FEAT_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int SDATA_W  = 80;
    localparam int MDATA_W  = 8;
    localparam int VOTE_SAT = 15;

    // Request kind carried on the input tuser.
    typedef enum logic [0:0] {
        OP_WRITE_TREE = 1'b0,
        OP_FEATURE    = 1'b1
    } op_t;

    // One stored stump.
    typedef struct packed {
        logic [FEAT_W-1:0]         feat;
        logic signed [VALUE_W-1:0] thr;
        logic [CLASS_W-1:0]        cls_low;
        logic [CLASS_W-1:0]        cls_high;
    } stump_t;

endpackage

// File: rtl/stump_forest_majority_vote_core.sv
// Decision-stump forest inference with majority vote, single top-level module.
// Depends on sfmv_pkg for stump type, request codes and default sizes.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------------
//  s_*     | in  | s_tvalid/tready  | tdata: stump fields + sample value, tuser: kind,
//          |     |                  | tlast: last feature of the sample
//  m_*     | out | m_tvalid/tready  | tdata: class + votes, tuser: short-sample flag
//
// Stump writes and non-final features are taken in ST_IDLE, which they do not leave. A
// final feature starts the vote: per tree a feature fetch (ST_FETCH) then compare and tally
// (ST_VOTE), argmax over classes (ST_SCAN), result load (ST_DONE); s_tready is low till idle.
// A pending result waits in the output register; if it is still not taken when the
// next vote finishes, the core holds in its last state until m_tready.
// Reset (rst_n, async) clears the stump table, the feature count and all control.
module stump_forest_majority_vote_core #(
    parameter int TREES    = sfmv_pkg::TREES_DEF,
    parameter int CLASSES  = sfmv_pkg::CLASSES_DEF,
    parameter int FEATURES = sfmv_pkg::FEATURES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [3:0] tree_slot, [7:4] split_feature, [39:8] split_threshold,
    // [43:40] class_if_at_or_below, [47:44] class_if_above, [79:48] sample_value
    input  logic [sfmv_pkg::SDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [3:0] predicted_class, [7:4] winning_votes
    output logic [sfmv_pkg::MDATA_W-1:0] m_tdata,
    // [0] short_sample
    output logic                         m_tuser
);

    localparam int TIDX_W = (TREES > 1) ? $clog2(TREES) : 1;
    localparam int CIDX_W = $clog2(CLASSES);
    localparam int FIDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int CNT_W  = $clog2(FEATURES + 1);
    localparam int VOTE_W = $clog2(TREES + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_VOTE  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // Saturate an incoming class label into range.
    function automatic logic [sfmv_pkg::CLASS_W-1:0] clamp_class(
        input logic [sfmv_pkg::CLASS_W-1:0] c
    );
        logic [sfmv_pkg::CLASS_W:0] wide;
        wide = {1'b0, c};
        if (wide >= (sfmv_pkg::CLASS_W + 1)'(CLASSES))
            return sfmv_pkg::CLASS_W'(CLASSES - 1);
        return c;
    endfunction

    // Input field unpacking.
    logic [3:0]                          in_slot;
    sfmv_pkg::stump_t                    in_stump;
    logic [sfmv_pkg::VALUE_W-1:0]        in_value;
    logic                                accept;
    logic                                is_feature;

    assign in_slot           = s_tdata[3:0];
    assign in_stump.feat     = s_tdata[7:4];
    assign in_stump.thr      = s_tdata[39:8];
    assign in_stump.cls_low  = clamp_class(s_tdata[43:40]);
    assign in_stump.cls_high = clamp_class(s_tdata[47:44]);
    assign in_value          = s_tdata[79:48];
    assign accept            = s_tvalid && s_tready;
    assign is_feature        = (s_tuser == sfmv_pkg::OP_FEATURE);

    // State.
    state_t                       state_reg, state_next;
    sfmv_pkg::stump_t             tree_table_reg [TREES];
    logic [sfmv_pkg::VALUE_W-1:0] feature_store  [FEATURES];
    logic [sfmv_pkg::VALUE_W-1:0] rd_data_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [TIDX_W-1:0]            tree_idx_reg, tree_idx_next;
    logic [CIDX_W-1:0]            class_idx_reg, class_idx_next;
    logic [VOTE_W-1:0]            votes_reg [CLASSES];
    logic [CIDX_W-1:0]            best_cls_reg, best_cls_next;
    logic [VOTE_W-1:0]            best_votes_reg, best_votes_next;
    logic                         short_reg, short_next;
    logic                         out_valid_reg, out_valid_next;
    logic [sfmv_pkg::CLASS_W-1:0] out_class_reg;
    logic [3:0]                   out_votes_reg;
    logic                         out_short_reg;

    // Shared compare unit: the current stump against its fetched feature.
    sfmv_pkg::stump_t             cur;
    logic                         feat_present;
    logic signed [sfmv_pkg::VALUE_W-1:0] cmp_value;
    logic                         at_or_below;
    logic [sfmv_pkg::CLASS_W-1:0] vote_cls;
    logic                         store_wr;
    logic                         table_wr;
    logic                         tally;
    logic                         clear_votes;
    logic                         load_out;
    logic                         votes_sat;

    assign cur          = tree_table_reg[tree_idx_reg];
    assign feat_present = (8'(cur.feat) < 8'(count_reg)) && (8'(cur.feat) < 8'(FEATURES));
    assign cmp_value    = feat_present ? $signed(rd_data_reg) : '0;
    assign at_or_below  = (cmp_value <= cur.thr);
    assign vote_cls     = at_or_below ? cur.cls_low : cur.cls_high;
    assign votes_sat    = (32'(best_votes_reg) > 32'(sfmv_pkg::VOTE_SAT));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_votes_reg, out_class_reg};
    assign m_tuser  = out_short_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        tree_idx_next   = tree_idx_reg;
        class_idx_next  = class_idx_reg;
        best_cls_next   = best_cls_reg;
        best_votes_next = best_votes_reg;
        short_next      = short_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        store_wr        = 1'b0;
        table_wr        = 1'b0;
        tally           = 1'b0;
        clear_votes     = 1'b0;
        load_out        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !is_feature)
                begin
                    // Drop writes to slots past the table.
                    table_wr = ({2'b00, in_slot} < 6'(TREES));
                end
                else if (accept)
                begin
                    // Drop features past capacity, but still honor tlast.
                    if (count_reg < CNT_W'(FEATURES))
                    begin
                        store_wr   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        clear_votes   = 1'b1;
                        tree_idx_next = '0;
                        short_next    = 1'b0;
                        state_next    = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_VOTE;
            end
            ST_VOTE:
            begin
                tally = 1'b1;
                if (!feat_present)
                    short_next = 1'b1;
                if (tree_idx_reg == TIDX_W'(TREES - 1))
                begin
                    class_idx_next  = '0;
                    best_cls_next   = '0;
                    best_votes_next = '0;
                    state_next      = ST_SCAN;
                end
                else
                begin
                    tree_idx_next = tree_idx_reg + 1'b1;
                    state_next    = ST_FETCH;
                end
            end
            ST_SCAN:
            begin
                // Strict greater keeps the lowest class on ties.
                if (votes_reg[class_idx_reg] > best_votes_reg)
                begin
                    best_votes_next = votes_reg[class_idx_reg];
                    best_cls_next   = class_idx_reg;
                end
                if (class_idx_reg == CIDX_W'(CLASSES - 1))
                    state_next = ST_DONE;
                else
                    class_idx_next = class_idx_reg + 1'b1;
            end
            ST_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || m_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            tree_idx_reg   <= '0;
            class_idx_reg  <= '0;
            best_cls_reg   <= '0;
            best_votes_reg <= '0;
            short_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TREES; i++)
                tree_table_reg[i] <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            tree_idx_reg   <= tree_idx_next;
            class_idx_reg  <= class_idx_next;
            best_cls_reg   <= best_cls_next;
            best_votes_reg <= best_votes_next;
            short_reg      <= short_next;
            out_valid_reg  <= out_valid_next;
            if (table_wr)
                tree_table_reg[TIDX_W'(in_slot)] <= in_stump;
        end
    end

    // Feature store: one write port on accept, one registered read port.
    always_ff @(posedge clk)
    begin
        if (store_wr)
            feature_store[count_reg[FIDX_W-1:0]] <= in_value;
        rd_data_reg <= feature_store[FIDX_W'(cur.feat)];
    end

    // Vote counters and result register.
    always_ff @(posedge clk)
    begin
        if (clear_votes)
        begin
            for (int c = 0; c < CLASSES; c++)
                votes_reg[c] <= '0;
        end
        else if (tally)
            votes_reg[CIDX_W'(vote_cls)] <= VOTE_W'(votes_reg[CIDX_W'(vote_cls)] + 1'b1);

        if (load_out)
        begin
            out_class_reg <= sfmv_pkg::CLASS_W'(best_cls_reg);
            out_votes_reg <= votes_sat ? 4'(sfmv_pkg::VOTE_SAT) : 4'(best_votes_reg);
            out_short_reg <= short_reg;
        end
    end

endmodule

// File: rtl/sfmv_checker.sv
// Port-level checker for the stump forest voter, bound to the top level.
// Depends on sfmv_pkg for request codes and field widths.
module sfmv_checker #(
    parameter int CLASSES = sfmv_pkg::CLASSES_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         s_tuser,
    input logic                         s_tlast,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [sfmv_pkg::MDATA_W-1:0] m_tdata,
    input logic                         m_tuser
);

    logic req_in;

    assign req_in = s_tvalid && s_tready;

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The final feature starts a vote, so the input side goes busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_in && (s_tuser == sfmv_pkg::OP_FEATURE) && s_tlast |=> !s_tready)
        else $error("still ready after final feature");

    // Stump writes and non-final features leave the input side ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_in && ((s_tuser == sfmv_pkg::OP_WRITE_TREE) || !s_tlast) |=> s_tready)
        else $error("busy after a single-cycle request");

    // A winning class is always a legal class.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[3:0]} < 5'(CLASSES)))
        else $error("predicted class out of range");

    // Every stump votes, so the winner has at least one vote.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:4] != 4'd0))
        else $error("winner with zero votes");

endmodule

bind stump_forest_majority_vote_core sfmv_checker #(.CLASSES(CLASSES)) u_sfmv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sfmv_vote_checker.sv
// Port checker for the stump forest voter: watches both stream channels, predicts each vote
// from its own copy of the stump table and feature store, and compares the results.
// Depends on sfmv_pkg for the stump type, request kinds and field widths.
module sfmv_vote_checker #(
    parameter int TREES    = sfmv_pkg::TREES_DEF,
    parameter int CLASSES  = sfmv_pkg::CLASSES_DEF,
    parameter int FEATURES = sfmv_pkg::FEATURES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [sfmv_pkg::SDATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         s_tlast,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [sfmv_pkg::MDATA_W-1:0] m_tdata,
    input  logic                         m_tuser,
    output int                           mismatch_count,
    output int                           pending_results
);
    import sfmv_pkg::*;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [CLASS_W-1:0] votes;
        logic               short_flag;
    } vote_result_t;

    stump_t             forest [TREES];
    logic [VALUE_W-1:0] feature_store [FEATURES];
    int unsigned        features_held;
    vote_result_t       expected_votes [$];
    int                 errors = 0;

    assign mismatch_count = errors;

    function automatic logic [CLASS_W-1:0] clamp_class(input logic [CLASS_W-1:0] c);
        return (c >= CLASSES) ? CLASS_W'(CLASSES - 1) : c;
    endfunction

    // Let every stump vote on the features held so far; pick the top class, lowest on ties.
    function automatic vote_result_t forest_vote();
        int unsigned               tally [CLASSES];
        logic signed [VALUE_W-1:0] x;
        logic signed [VALUE_W-1:0] limit;
        logic [CLASS_W-1:0]        pick;
        int unsigned               best;
        int unsigned               best_n;
        vote_result_t              r;
        r = '0;
        foreach (tally[c])
            tally[c] = 0;
        for (int t = 0; t < TREES; t++)
        begin
            limit = forest[t].thr;
            if (forest[t].feat < features_held && forest[t].feat < FEATURES)
                x = feature_store[forest[t].feat];
            else
            begin
                x = '0;
                r.short_flag = 1'b1;
            end
            pick = (x <= limit) ? forest[t].cls_low : forest[t].cls_high;
            if (pick < CLASSES)
                tally[pick]++;
        end
        best   = 0;
        best_n = tally[0];
        for (int c = 1; c < CLASSES; c++)
        begin
            if (tally[c] > best_n)
            begin
                best_n = tally[c];
                best   = c;
            end
        end
        if (best_n > VOTE_SAT)
            best_n = VOTE_SAT;
        r.cls   = CLASS_W'(best);
        r.votes = CLASS_W'(best_n);
        return r;
    endfunction

    always @(posedge clk)
    begin
        vote_result_t        got;
        vote_result_t        want;
        logic [FEAT_W-1:0]   slot;
        if (!rst_n)
        begin
            foreach (forest[t])
                forest[t] = '0;
            foreach (feature_store[f])
                feature_store[f] = '0;
            features_held = 0;
            expected_votes.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.cls        = m_tdata[3:0];
                got.votes      = m_tdata[7:4];
                got.short_flag = m_tuser;
                if (expected_votes.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: vote result with none pending:", $realtime,
                                 " class %0d votes %0d short %0b",
                                 got.cls, got.votes, got.short_flag);
                end
                else
                begin
                    want = expected_votes.pop_front();
                    if (got.cls !== want.cls || got.votes !== want.votes
                        || got.short_flag !== want.short_flag)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: vote result differs:", $realtime,
                                     " expected class %0d votes %0d short %0b,",
                                     want.cls, want.votes, want.short_flag,
                                     " got class %0d votes %0d short %0b",
                                     got.cls, got.votes, got.short_flag);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (op_t'(s_tuser) == OP_WRITE_TREE)
                begin
                    slot = s_tdata[3:0];
                    if (slot < TREES)
                        forest[slot] = '{feat:     s_tdata[7:4],
                                         thr:      s_tdata[39:8],
                                         cls_low:  clamp_class(s_tdata[43:40]),
                                         cls_high: clamp_class(s_tdata[47:44])};
                end
                else
                begin
                    if (features_held < FEATURES)
                    begin
                        feature_store[features_held] = s_tdata[79:48];
                        features_held++;
                    end
                    if (s_tlast)
                    begin
                        expected_votes = {expected_votes, forest_vote()};
                        features_held = 0;
                    end
                end
            end
        end
        pending_results <= expected_votes.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the stump forest voter bench: clock, reset, request stimulus, output backpressure
// and the verdict. Depends on sfmv_pkg, stump_forest_majority_vote_core and sfmv_vote_checker.
module testbench;
    import sfmv_pkg::*;

    localparam int TREES    = TREES_DEF;
    localparam int CLASSES  = CLASSES_DEF;
    localparam int FEATURES = FEATURES_DEF;
    localparam int REQUESTS = 1600;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [SDATA_W-1:0] s_tdata;
    logic               s_tuser;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [MDATA_W-1:0] m_tdata;
    logic               m_tuser;

    int mismatch_count;
    int pending_results;

    // Idle chances in percent, switched by the stimulus as the run moves through its phases.
    int send_idle_pct = 12;
    int recv_idle_pct = 84;
    bit hold_receiver = 1'b0;
    int requests_sent = 0;

    stump_forest_majority_vote_core #(
        .TREES    (TREES),
        .CLASSES  (CLASSES),
        .FEATURES (FEATURES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sfmv_vote_checker #(
        .TREES    (TREES),
        .CLASSES  (CLASSES),
        .FEATURES (FEATURES)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    // Q16.16 value: half of the time small whole numbers or tiny offsets, so that feature values
    // land on, just under and just over thresholds; extremes and full-range noise too.
    function automatic logic [VALUE_W-1:0] pick_q16();
        case ($urandom_range(0, 7))
            0, 1:    return VALUE_W'(int'($urandom_range(0, 8)) - 4);
            2, 3:    return VALUE_W'((int'($urandom_range(0, 8)) - 4) * 65536);
            4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Build a stump-write request; the unused sample value bits carry noise.
    function automatic logic [SDATA_W-1:0] stump_request(input int slot, input int feat,
                                                         input logic [VALUE_W-1:0] thr,
                                                         input int cls_lo, input int cls_hi);
        logic [SDATA_W-1:0] d;
        d = SDATA_W'({$urandom(), $urandom(), $urandom()});
        d[3:0]   = FEAT_W'(slot);
        d[7:4]   = FEAT_W'(feat);
        d[39:8]  = thr;
        d[43:40] = CLASS_W'(cls_lo);
        d[47:44] = CLASS_W'(cls_hi);
        return d;
    endfunction

    // Build a feature request; the unused stump fields carry noise.
    function automatic logic [SDATA_W-1:0] feature_request(input logic [VALUE_W-1:0] value);
        logic [SDATA_W-1:0] d;
        d = SDATA_W'({$urandom(), $urandom(), $urandom()});
        d[79:48] = value;
        return d;
    endfunction

    // Offer one request and hold it until accepted. Idle cycles drop tvalid first;
    // back-to-back requests keep tvalid high with no low/high in one step.
    task automatic send_request(input op_t op, input logic [SDATA_W-1:0] data, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Deliver one sample of random length; the last feature request triggers the vote.
    task automatic send_sample(input int len);
        for (int i = 0; i < len; i++)
            send_request(OP_FEATURE, feature_request(pick_q16()), i == len - 1);
    endtask

    // Receiver: random backpressure, plus one long hold-off counted here on request.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_receiver = 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int  drain;
        bit  paused;
        bit  held;
        logic [VALUE_W-1:0] v;
        paused = 1'b0;
        held   = 1'b0;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_WRITE_TREE;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Vote on the reset table: every stump reads feature 0 against zero, all for class 0.
        send_request(OP_FEATURE, feature_request($urandom()), 1'b1);

        // Threshold extremes and out-of-range class labels; the first write also
        // carries a last mark that a stump write must ignore.
        send_request(OP_WRITE_TREE, stump_request(0, 0, 32'h7FFF_FFFF, 9, 0), 1'b1);
        send_request(OP_WRITE_TREE, stump_request(1, 15, 32'h8000_0000, 15, 12), 1'b0);
        send_request(OP_WRITE_TREE, stump_request(9, 1, 32'h0000_0000, 3, 4), 1'b0);
        send_request(OP_WRITE_TREE, stump_request(2, 2, 32'hFFFF_FFFF, 5, 6), 1'b0);
        // Slots past the table: must leave it untouched.
        send_request(OP_WRITE_TREE, stump_request(10, 0, 32'h0000_0000, 2, 2), 1'b0);
        send_request(OP_WRITE_TREE, stump_request(15, 3, 32'h0001_0000, 7, 7), 1'b0);

        // Short sample: one feature, so stumps on features 1, 2 and 15 see zero.
        send_request(OP_FEATURE, feature_request(32'h8000_0000), 1'b1);

        // Full sample plus one past capacity; values sit exactly on the thresholds.
        for (int i = 0; i < FEATURES + 1; i++)
        begin
            case (i)
                0:        v = 32'h7FFF_FFFF;
                1:        v = 32'h0000_0000;
                2:        v = 32'hFFFF_FFFF;
                15:       v = 32'h8000_0000;
                default:  v = pick_q16();
            endcase
            send_request(OP_FEATURE, feature_request(v), i == FEATURES);
        end

        // Random part: mostly well-formed samples of in-range length between stump writes.
        while (requests_sent < REQUESTS)
        begin
            if (requests_sent >= REQUESTS / 3 && requests_sent < 2 * REQUESTS / 3)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 12;
            end
            else if (requests_sent >= 2 * REQUESTS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // Pause once between samples until every vote result is out.
            if (!paused && requests_sent >= REQUESTS / 2)
            begin
                paused = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results != 0)
                    @(posedge clk);
            end

            // Stall the output for a long stretch while requests keep coming at full rate.
            if (!held && requests_sent >= 2 * REQUESTS / 3 + 40)
            begin
                held = 1'b1;
                hold_receiver = 1'b1;
            end

            if ($urandom_range(0, 99) < 20)
                send_request(OP_WRITE_TREE,
                             stump_request(($urandom_range(0, 99) < 85) ? $urandom_range(0, 9)
                                                                        : $urandom_range(10, 15),
                                           $urandom_range(0, 15), pick_q16(),
                                           ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9)
                                                                        : $urandom_range(10, 15),
                                           ($urandom_range(0, 99) < 85) ? $urandom_range(0, 9)
                                                                        : $urandom_range(10, 15)),
                             $urandom_range(0, 1));
            else
                send_sample(($urandom_range(0, 99) < 85) ? $urandom_range(1, FEATURES)
                                                         : $urandom_range(FEATURES + 1, 20));
        end

        // Drain: wait for the outstanding votes, then for any vote still in progress to finish.
        s_tvalid <= 1'b0;
        @(posedge clk);
        drain = 0;
        while (pending_results != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (2 * TREES + CLASSES + 10) @(posedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sfmv_pkg.sv
rtl/stump_forest_majority_vote_core.sv
rtl/sfmv_checker.sv
tb/sfmv_vote_checker.sv
tb/testbench.sv
